// File: hw/rtl/quaternion_vector_rotate_assert.svh
// Assertion macros shared by the quaternion rotation RTL.
// Included by the modules that check their own pipeline behavior; no other dependency.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef QUATERNION_VECTOR_ROTATE_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define QVR_ASSERT_IMPL(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("implication check failed");

// Next-cycle implication.
`define QVR_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");

`else

`define QVR_ASSERT_IMPL(name, pre, post)
`define QVR_ASSERT_NEXT(name, pre, post)

`endif

`endif

// File: hw/rtl/qvr_pkg.sv
// Shared constants and types for the quaternion vector rotation block.
// Used by qvr_div_pipe and quaternion_vector_rotate; depends on nothing.
package qvr_pkg;

    localparam int COMP_WIDTH_DEF = 16;
    localparam int LANES          = 3;

    // Side information that travels with an item through the divider.
    typedef struct packed {
        logic [LANES-1:0] neg;
        logic             zero;
    } qvr_side_t;

endpackage

// File: hw/rtl/qvr_div_pipe.sv
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
// Depends on qvr_pkg and quaternion_vector_rotate_assert.svh.
`include "quaternion_vector_rotate_assert.svh"

module qvr_div_pipe #(
    parameter int COMP_WIDTH = qvr_pkg::COMP_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [3*COMP_WIDTH+2:0]     num [qvr_pkg::LANES],
    input  logic [2*COMP_WIDTH:0]       den,
    input  qvr_pkg::qvr_side_t          side,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [COMP_WIDTH:0]         quo [qvr_pkg::LANES],
    output qvr_pkg::qvr_side_t          out_side
);
    import qvr_pkg::*;

    localparam int W     = COMP_WIDTH;
    localparam int QB    = W + 1;
    localparam int MW    = 3 * W + 3;
    localparam int RW    = 2 * W + 2;
    localparam int DEN_W = 2 * W + 1;

    logic [QB-1:0]    vld_reg;
    logic [QB:0]      rdy;
    logic [MW-1:0]    num_reg  [QB][LANES];
    logic [RW-1:0]    rem_reg  [QB][LANES];
    logic [QB-1:0]    quo_reg  [QB][LANES];
    logic [DEN_W-1:0] den_reg  [QB];
    qvr_side_t        side_reg [QB];
    logic [RW-1:0]    den_ext;

    assign rdy[QB]   = out_ready;
    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[QB-1];

    for (genvar s = 0; s < QB; s++) begin : g_stage
        logic             v_in;
        logic [MW-1:0]    n_in [LANES];
        logic [RW-1:0]    r_in [LANES];
        logic [QB-1:0]    q_in [LANES];
        logic [DEN_W-1:0] d_in;
        qvr_side_t        s_in;
        logic [RW-1:0]    rem_next [LANES];
        logic [QB-1:0]    quo_next [LANES];

        if (s == 0) begin : g_first
            assign v_in = in_valid;
            assign d_in = den;
            assign s_in = side;
            for (genvar c = 0; c < LANES; c++) begin : g_lane
                assign n_in[c] = num[c];
                // The top bits of the numerator are known to stay below the divisor.
                assign r_in[c] = num[c][MW-1:QB];
                assign q_in[c] = '0;
            end
        end else begin : g_rest
            assign v_in = vld_reg[s-1];
            assign d_in = den_reg[s-1];
            assign s_in = side_reg[s-1];
            for (genvar c = 0; c < LANES; c++) begin : g_lane
                assign n_in[c] = num_reg[s-1][c];
                assign r_in[c] = rem_reg[s-1][c];
                assign q_in[c] = quo_reg[s-1][c];
            end
        end

        always_comb
        begin
            for (int c = 0; c < LANES; c++)
            begin
                rem_next[c] = {r_in[c][RW-2:0], n_in[c][QB-1-s]};
                quo_next[c] = {q_in[c][QB-2:0], 1'b0};
                if (rem_next[c] >= {1'b0, d_in})
                begin
                    rem_next[c] = rem_next[c] - {1'b0, d_in};
                    quo_next[c] = {q_in[c][QB-2:0], 1'b1};
                end
            end
        end

        assign rdy[s] = !vld_reg[s] || rdy[s+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (rdy[s])
            begin
                vld_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[s] && v_in)
            begin
                den_reg[s]  <= d_in;
                side_reg[s] <= s_in;
                for (int c = 0; c < LANES; c++)
                begin
                    num_reg[s][c] <= n_in[c];
                    rem_reg[s][c] <= rem_next[c];
                    quo_reg[s][c] <= quo_next[c];
                end
            end
        end
    end

    // Round half away from zero: bump when twice the remainder reaches the divisor.
    always_comb
    begin
        for (int c = 0; c < LANES; c++)
        begin
            quo[c] = quo_reg[QB-1][c]
                   + QB'({rem_reg[QB-1][c], 1'b0} >= {2'b00, den_reg[QB-1]});
        end
    end

    assign out_side = side_reg[QB-1];
    assign den_ext  = {1'b0, den_reg[QB-1]};

    `QVR_ASSERT_IMPL(a_rem_lane0, out_valid && !out_side.zero, rem_reg[QB-1][0] < den_ext)
    `QVR_ASSERT_IMPL(a_rem_lane1, out_valid && !out_side.zero, rem_reg[QB-1][1] < den_ext)
    `QVR_ASSERT_IMPL(a_rem_lane2, out_valid && !out_side.zero, rem_reg[QB-1][2] < den_ext)

endmodule

// File: hw/rtl/quaternion_vector_rotate.sv
// Quaternion vector rotation, top level: products, numerator, divider and saturation.
// Depends on qvr_pkg, qvr_div_pipe and quaternion_vector_rotate_assert.svh.
//
// Usage: an item (quat_w/x/y/z in Q1.14, vec_x/y/z in Q8.7) is a transfer on the input
// channel (in_valid and in_ready high). Each item gives one result transfer on the output
// channel: rot_x/y/z = vector part of q*v*q^-1 in Q8.7, rounded half away from zero and
// saturated, with clipped set when any component saturated and zero_norm set (result
// zero) for an all-zero quaternion.
// The path is four stages of products and sums, COMP_WIDTH + 1 divider stages that
// each resolve one quotient bit, and the output register. One item is accepted every
// cycle while out_ready stays high; most of the pipeline depth lies in the divider.
// Reset clears all valid bits; the pipeline then starts empty.
// When the receiver holds out_ready low, stages stall from the output backward only
// as far as they are full, so empty stages keep taking items until the pipe is full.
`include "quaternion_vector_rotate_assert.svh"

module quaternion_vector_rotate #(
    parameter int COMP_WIDTH = qvr_pkg::COMP_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COMP_WIDTH-1:0] quat_x,
    input  logic signed [COMP_WIDTH-1:0] quat_y,
    input  logic signed [COMP_WIDTH-1:0] quat_z,
    input  logic signed [COMP_WIDTH-1:0] quat_w,
    input  logic signed [COMP_WIDTH-1:0] vec_x,
    input  logic signed [COMP_WIDTH-1:0] vec_y,
    input  logic signed [COMP_WIDTH-1:0] vec_z,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COMP_WIDTH-1:0] rot_x,
    output logic signed [COMP_WIDTH-1:0] rot_y,
    output logic signed [COMP_WIDTH-1:0] rot_z,
    output logic                         zero_norm,
    output logic                         clipped
);
    import qvr_pkg::*;

    localparam int W     = COMP_WIDTH;
    localparam int PW    = 2 * W;
    localparam int AW    = 2 * W + 2;
    localparam int TW    = 3 * W + 2;
    localparam int CW    = 3 * W;
    localparam int NW    = 3 * W + 4;
    localparam int MW    = 3 * W + 3;
    localparam int QB    = W + 1;
    localparam int DEN_W = 2 * W + 1;

    // Square and cross product slots.
    localparam int SW = 0;
    localparam int SX = 1;
    localparam int SY = 2;
    localparam int SZ = 3;
    localparam int PXY = 0;
    localparam int PXZ = 1;
    localparam int PYZ = 2;
    localparam int PWX = 3;
    localparam int PWY = 4;
    localparam int PWZ = 5;
    localparam int VX = 0;
    localparam int VY = 1;
    localparam int VZ = 2;

    localparam logic [QB-1:0] HALF_Q  = QB'(1) << (W - 1);
    localparam logic [W-1:0]  MAX_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  MIN_NEG = {1'b1, {(W-1){1'b0}}};

    logic [3:0] vld_reg;
    logic [4:0] rdy;

    logic signed [PW-1:0]  sq_reg   [4];
    logic signed [PW-1:0]  pr_reg   [6];
    logic signed [W-1:0]   v1_reg   [3];
    logic signed [AW-1:0]  a2_reg   [3];
    logic signed [AW-1:0]  norm2_reg;
    logic signed [PW-1:0]  pr2_reg  [6];
    logic signed [W-1:0]   v2_reg   [3];
    logic signed [TW-1:0]  av3_reg  [3];
    logic signed [CW-1:0]  c3_reg   [3][4];
    logic [DEN_W-1:0]      norm3_reg;
    logic                  zero3_reg;
    logic [MW-1:0]         num4_reg [3];
    logic [DEN_W-1:0]      norm4_reg;
    qvr_side_t             side4_reg;

    logic signed [NW-1:0]  cs_sum   [3];
    logic signed [NW-1:0]  n_sum    [3];
    logic [MW-1:0]         num_next [3];
    logic [LANES-1:0]      neg_next;

    logic                  div_in_ready;
    logic                  div_out_valid;
    logic                  div_out_ready;
    logic [QB-1:0]         div_quo  [LANES];
    qvr_side_t             div_side;

    logic                  out_valid_reg;
    logic [W-1:0]          rot_reg  [3];
    logic [W-1:0]          rot_next [3];
    logic                  zero_reg;
    logic                  clip_reg;
    logic                  clip_next;

    assign rdy[4]   = div_in_ready;
    assign in_ready = rdy[0];

    for (genvar k = 0; k < 4; k++) begin : g_rdy
        assign rdy[k] = !vld_reg[k] || rdy[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0]) vld_reg[0] <= in_valid;
            if (rdy[1]) vld_reg[1] <= vld_reg[0];
            if (rdy[2]) vld_reg[2] <= vld_reg[1];
            if (rdy[3]) vld_reg[3] <= vld_reg[2];
        end
    end

    // Stage 1: squares and pairwise products of the quaternion.
    always_ff @(posedge clk)
    begin
        if (rdy[0] && in_valid)
        begin
            sq_reg[SW]  <= quat_w * quat_w;
            sq_reg[SX]  <= quat_x * quat_x;
            sq_reg[SY]  <= quat_y * quat_y;
            sq_reg[SZ]  <= quat_z * quat_z;
            pr_reg[PXY] <= quat_x * quat_y;
            pr_reg[PXZ] <= quat_x * quat_z;
            pr_reg[PYZ] <= quat_y * quat_z;
            pr_reg[PWX] <= quat_w * quat_x;
            pr_reg[PWY] <= quat_w * quat_y;
            pr_reg[PWZ] <= quat_w * quat_z;
            v1_reg[VX]  <= vec_x;
            v1_reg[VY]  <= vec_y;
            v1_reg[VZ]  <= vec_z;
        end
    end

    // Stage 2: diagonal coefficients (w^2 + own^2 - other squares) and the squared norm.
    always_ff @(posedge clk)
    begin
        if (rdy[1] && vld_reg[0])
        begin
            a2_reg[VX] <= AW'(sq_reg[SW]) + AW'(sq_reg[SX]) - AW'(sq_reg[SY]) - AW'(sq_reg[SZ]);
            a2_reg[VY] <= AW'(sq_reg[SW]) + AW'(sq_reg[SY]) - AW'(sq_reg[SZ]) - AW'(sq_reg[SX]);
            a2_reg[VZ] <= AW'(sq_reg[SW]) + AW'(sq_reg[SZ]) - AW'(sq_reg[SX]) - AW'(sq_reg[SY]);
            norm2_reg  <= AW'(sq_reg[SW]) + AW'(sq_reg[SX]) + AW'(sq_reg[SY]) + AW'(sq_reg[SZ]);
            pr2_reg    <= pr_reg;
            v2_reg     <= v1_reg;
        end
    end

    // Stage 3: every coefficient times its vector component.
    always_ff @(posedge clk)
    begin
        if (rdy[2] && vld_reg[1])
        begin
            for (int c = 0; c < 3; c++)
            begin
                av3_reg[c] <= TW'(a2_reg[c]) * TW'(v2_reg[c]);
            end
            c3_reg[VX][0] <= CW'(pr2_reg[PXY]) * CW'(v2_reg[VY]);
            c3_reg[VX][1] <= CW'(pr2_reg[PXZ]) * CW'(v2_reg[VZ]);
            c3_reg[VX][2] <= CW'(pr2_reg[PWY]) * CW'(v2_reg[VZ]);
            c3_reg[VX][3] <= CW'(pr2_reg[PWZ]) * CW'(v2_reg[VY]);
            c3_reg[VY][0] <= CW'(pr2_reg[PYZ]) * CW'(v2_reg[VZ]);
            c3_reg[VY][1] <= CW'(pr2_reg[PXY]) * CW'(v2_reg[VX]);
            c3_reg[VY][2] <= CW'(pr2_reg[PWZ]) * CW'(v2_reg[VX]);
            c3_reg[VY][3] <= CW'(pr2_reg[PWX]) * CW'(v2_reg[VZ]);
            c3_reg[VZ][0] <= CW'(pr2_reg[PXZ]) * CW'(v2_reg[VX]);
            c3_reg[VZ][1] <= CW'(pr2_reg[PYZ]) * CW'(v2_reg[VY]);
            c3_reg[VZ][2] <= CW'(pr2_reg[PWX]) * CW'(v2_reg[VY]);
            c3_reg[VZ][3] <= CW'(pr2_reg[PWY]) * CW'(v2_reg[VX]);
            norm3_reg     <= norm2_reg[DEN_W-1:0];
            zero3_reg     <= (norm2_reg == '0);
        end
    end

    // Stage 4: full numerator, split into sign and magnitude for the divider.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            cs_sum[c]   = NW'(c3_reg[c][0]) + NW'(c3_reg[c][1]) + NW'(c3_reg[c][2])
                        - NW'(c3_reg[c][3]);
            n_sum[c]    = NW'(av3_reg[c]) + (cs_sum[c] <<< 1);
            neg_next[c] = n_sum[c][NW-1];
            num_next[c] = neg_next[c] ? MW'(-n_sum[c]) : MW'(n_sum[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[3] && vld_reg[2])
        begin
            num4_reg       <= num_next;
            norm4_reg      <= norm3_reg;
            side4_reg.neg  <= neg_next;
            side4_reg.zero <= zero3_reg;
        end
    end

    qvr_div_pipe #(
        .COMP_WIDTH (COMP_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[3]),
        .in_ready  (div_in_ready),
        .num       (num4_reg),
        .den       (norm4_reg),
        .side      (side4_reg),
        .out_valid (div_out_valid),
        .out_ready (div_out_ready),
        .quo       (div_quo),
        .out_side  (div_side)
    );

    // Output stage: restore the sign and saturate.
    always_comb
    begin
        clip_next = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            if (div_side.zero)
            begin
                rot_next[c] = '0;
            end
            else if (div_side.neg[c])
            begin
                if (div_quo[c] > HALF_Q)
                begin
                    rot_next[c] = MIN_NEG;
                    clip_next   = 1'b1;
                end
                else
                begin
                    rot_next[c] = W'(~div_quo[c] + QB'(1));
                end
            end
            else
            begin
                if (div_quo[c] > HALF_Q - QB'(1))
                begin
                    rot_next[c] = MAX_POS;
                    clip_next   = 1'b1;
                end
                else
                begin
                    rot_next[c] = div_quo[c][W-1:0];
                end
            end
        end
    end

    assign div_out_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (div_out_ready)
        begin
            out_valid_reg <= div_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_out_ready && div_out_valid)
        begin
            rot_reg  <= rot_next;
            zero_reg <= div_side.zero;
            clip_reg <= clip_next && !div_side.zero;
        end
    end

    assign out_valid = out_valid_reg;
    assign rot_x     = rot_reg[VX];
    assign rot_y     = rot_reg[VY];
    assign rot_z     = rot_reg[VZ];
    assign zero_norm = zero_reg;
    assign clipped   = clip_reg;

    `QVR_ASSERT_IMPL(a_zero_result, out_valid && zero_norm, rot_x == 0 && rot_y == 0 && rot_z == 0 && !clipped)
    `QVR_ASSERT_IMPL(a_clip_extreme, out_valid && clipped, rot_reg[VX] == MAX_POS || rot_reg[VX] == MIN_NEG || rot_reg[VY] == MAX_POS || rot_reg[VY] == MIN_NEG || rot_reg[VZ] == MAX_POS || rot_reg[VZ] == MIN_NEG)
    `QVR_ASSERT_NEXT(a_front_hold, vld_reg[3] && !div_in_ready, vld_reg[3])

endmodule
